// ----- rtl/mbag_pkg.sv -----
package mbag_pkg;

	localparam int ACTION_W    = 3;
	localparam int VALUE_W     = 32;
	localparam int RES_CNT_W   = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD      = 3'd0,
		ACT_REMOVE   = 3'd1,
		ACT_COUNT    = 3'd2,
		ACT_CONTAINS = 3'd3,
		ACT_CLEAR    = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic                 is_empty;
		logic [RES_CNT_W-1:0] current_size;
		logic [RES_CNT_W-1:0] match_count;
		logic                 ok;
	} res_t;

endpackage

// ----- rtl/mbag_ram.sv -----
module mbag_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/mbag_engine.sv -----
module mbag_engine #(
	parameter int CAPACITY   = 64,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mbag_pkg::ACTION_W-1:0]     action,
	input  logic [mbag_pkg::VALUE_W-1:0]      item_value,
	output logic                              res_valid,
	input  logic                              res_ready,
	output mbag_pkg::res_t                    res
);

	import mbag_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                state_q, state_d;
	act_t                  act_q;
	logic [ITEM_WIDTH-1:0] key_q;
	logic [ITEM_WIDTH-1:0] in_key;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         idx_q, idx_d;
	logic [CW-1:0]         match_q, match_d;
	logic [CW-1:0]         last;
	logic                  ok_q, ok_d;
	logic [AW-1:0]         pos_q, pos_d;
	logic                  vld_s1;
	logic [CW-1:0]         idx_s1;
	logic                  full;
	logic                  hit;
	logic                  accept;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ITEM_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [ITEM_WIDTH-1:0] ram_rdata;

	mbag_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(ITEM_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_key = ITEM_WIDTH'(item_value);
	assign full   = (count_q == CW'(CAPACITY));
	assign last   = count_q - CW'(1);
	assign hit    = vld_s1 && (ram_rdata == key_q);
	assign accept = in_valid && in_ready;

	assign res.ok           = ok_q;
	assign res.match_count  = RES_CNT_W'(match_q);
	assign res.current_size = RES_CNT_W'(count_q);
	assign res.is_empty     = (count_q == '0);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		match_d   = match_q;
		ok_d      = ok_q;
		pos_d     = pos_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = in_key;
		ram_raddr = idx_q[AW-1:0];
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESP);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					idx_d   = '0;
					match_d = '0;
					ok_d    = 1'b0;
					state_d = ST_RESP;
					case (act_t'(action))
						ACT_ADD: begin
							if (!full) begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
								ok_d    = 1'b1;
							end
						end
						ACT_CLEAR: begin
							count_d = '0;
							ok_d    = 1'b1;
						end
						ACT_COUNT: begin
							ok_d = 1'b1;
							if (count_q != '0) begin
								state_d = ST_SCAN;
							end
						end
						ACT_REMOVE, ACT_CONTAINS: begin
							if (count_q != '0) begin
								state_d = ST_SCAN;
							end
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (idx_q < count_q) begin
					idx_d = idx_q + CW'(1);
				end
				if (vld_s1) begin
					if (act_q == ACT_COUNT) begin
						if (hit) begin
							match_d = match_q + CW'(1);
						end
						if (idx_s1 == last) begin
							state_d = ST_RESP;
						end
					end else if (hit) begin
						if (act_q == ACT_REMOVE) begin
							pos_d   = idx_s1[AW-1:0];
							state_d = ST_MOVE_RD;
						end else begin
							ok_d    = 1'b1;
							state_d = ST_RESP;
						end
					end else if (idx_s1 == last) begin
						state_d = ST_RESP;
					end
				end
			end
			ST_MOVE_RD: begin
				ram_raddr = last[AW-1:0];
				state_d   = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = ram_rdata;
				count_d   = last;
				ok_d      = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_s1  <= (state_q == ST_SCAN) && (idx_q < count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= act_t'(action);
			key_q <= in_key;
		end
		idx_q   <= idx_d;
		match_q <= match_d;
		ok_q    <= ok_d;
		pos_q   <= pos_d;
		idx_s1  <= idx_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("live count above capacity");

	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE_RD || state_q == ST_MOVE_WR) |-> count_q != '0)
		else $error("entry move with empty bag");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE || state_q == ST_MOVE_WR))
		else $error("memory write outside add or move");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE_WR |=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not shrink the bag");

endmodule

// ----- rtl/multiset_bag_table_top.sv -----
// Bag (multiset) of up to CAPACITY values of ITEM_WIDTH bits, kept packed at the front of
// a single-port-read entry memory. Add and clear skip the scan and go straight from input
// word to result word, as do lookups on an empty bag. Count reads every live entry through
// the one memory read port, one entry a cycle. Contains and remove stop at the first match;
// a remove that hits then reads the last live entry and writes it into the freed slot. One
// word is worked on at a time; a finished result waits in the output register while the
// next input word is taken.
module multiset_bag_table_top #(
	parameter int CAPACITY   = 64,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// action [2:0], item_value [34:3], zero [39:35]
	input  logic [mbag_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// ok [0], match_count [7:1], current_size [14:8], is_empty [15]
	output logic [mbag_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	import mbag_pkg::*;

	logic                   res_valid;
	logic                   res_ready;
	res_t                   res;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	mbag_engine #(
		.CAPACITY  (CAPACITY),
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.action    (s_axis_tdata[ACTION_W-1:0]),
		.item_value(s_axis_tdata[ACTION_W+VALUE_W-1:ACTION_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// hold the result word until taken
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= OUT_TDATA_W'(res);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
